// ----- hdl/ogru_pkg.sv -----
package ogru_pkg;

   localparam logic [1:0] ACT_RAY   = 2'd0;
   localparam logic [1:0] ACT_HIT   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_CLEAR = 2'd3;

   localparam logic [2:0] REG_FREE_COST  = 3'd0;
   localparam logic [2:0] REG_HIT_COST   = 3'd1;
   localparam logic [2:0] REG_MAX_RANGE  = 3'd2;
   localparam logic [2:0] REG_CPM        = 3'd3;
   localparam logic [2:0] REG_GRID_WIDTH = 3'd4;
   localparam logic [2:0] REG_GRID_HGT   = 3'd5;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_DATA_W = 16;

   localparam logic [3:0] CORDIC_LAST = 4'd15;
   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;

   typedef struct packed {
      logic load;
      logic mul;
      logic cinit;
      logic cstep;
      logic quad;
      logic addr;
      logic wr;
      logic clr;
      logic out_load;
   } ogru_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       cord_last;
      logic       steps_zero;
      logic       cnt_last;
      logic       clr_last;
   } ogru_status_type;

   function automatic logic signed [20:0] arc_entry(input logic [3:0] idx);
      logic signed [20:0] v;
      case (idx)
         4'd0:    v = 21'sd131072;
         4'd1:    v = 21'sd77376;
         4'd2:    v = 21'sd40884;
         4'd3:    v = 21'sd20753;
         4'd4:    v = 21'sd10417;
         4'd5:    v = 21'sd5213;
         4'd6:    v = 21'sd2607;
         4'd7:    v = 21'sd1304;
         4'd8:    v = 21'sd652;
         4'd9:    v = 21'sd326;
         4'd10:   v = 21'sd163;
         4'd11:   v = 21'sd81;
         4'd12:   v = 21'sd41;
         4'd13:   v = 21'sd20;
         4'd14:   v = 21'sd10;
         4'd15:   v = 21'sd5;
         default: v = 21'sd0;
      endcase
      return v;
   endfunction

endpackage

// ----- hdl/ogru_ctrl.sv -----
module ogru_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  ogru_pkg::ogru_status_type status,
   output ogru_pkg::ogru_cmd_type    cmd
);
   import ogru_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_CINIT, ST_CORD, ST_QUAD,
      ST_ADDR, ST_RD, ST_WR, ST_CLR, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      boot_ff, boot_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.mul      = (state_ff == ST_MUL);
      cmd.cinit    = (state_ff == ST_CINIT);
      cmd.cstep    = (state_ff == ST_CORD);
      cmd.quad     = (state_ff == ST_QUAD);
      cmd.addr     = (state_ff == ST_ADDR);
      cmd.wr       = (state_ff == ST_WR);
      cmd.clr      = (state_ff == ST_CLR);
      cmd.out_load = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_tready);
   end

   always_comb begin
      state_in     = state_ff;
      boot_in      = boot_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (status.action)
                  ACT_RAY:   state_in = ST_MUL;
                  ACT_CLEAR: state_in = ST_CLR;
                  default:   state_in = ST_ADDR;
               endcase
            end
         end
         ST_MUL:   state_in = ST_CINIT;
         ST_CINIT: state_in = ST_CORD;
         ST_CORD: begin
            if (status.cord_last) begin
               state_in = ST_QUAD;
            end
         end
         ST_QUAD:  state_in = status.steps_zero ? ST_FIN : ST_ADDR;
         ST_ADDR:  state_in = ST_RD;
         ST_RD:    state_in = ST_WR;
         ST_WR: begin
            if (status.action != ACT_RAY || status.cnt_last) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_CLR: begin
            if (status.clr_last) begin
               state_in = boot_ff ? ST_IDLE : ST_FIN;
               boot_in  = 1'b0;
            end
         end
         ST_FIN: begin
            if (cmd.out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         boot_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         boot_ff      <= boot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- hdl/ogru_dpath.sv -----
module ogru_dpath #(
   parameter int GRID_SIDE = 512
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  logic [2:0]                          csr_index,
   input  logic [ogru_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [ogru_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                          req_tuser,
   input  ogru_pkg::ogru_cmd_type              cmd,
   output ogru_pkg::ogru_status_type           status,
   output logic [ogru_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser
);
   import ogru_pkg::*;

   localparam int DEPTH  = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CW     = $clog2(GRID_SIDE);
   localparam logic [12:0] SIDE13 = 13'(GRID_SIDE);

   logic [7:0] mem [DEPTH];

   // configuration
   logic [6:0]  free_ff, hit_ff;
   logic [15:0] maxr_ff, cpm_ff;
   logic [9:0]  gw_ff, gh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= 7'd1;
         hit_ff  <= 7'd3;
         maxr_ff <= 16'd7680;
         cpm_ff  <= 16'd5120;
         gw_ff   <= 10'd512;
         gh_ff   <= 10'd512;
      end else if (csr_wen) begin
         case (csr_index)
            REG_FREE_COST:  free_ff <= csr_wdata[6:0];
            REG_HIT_COST:   hit_ff  <= csr_wdata[6:0];
            REG_MAX_RANGE:  maxr_ff <= csr_wdata;
            REG_CPM:        cpm_ff  <= csr_wdata;
            REG_GRID_WIDTH: gw_ff   <= csr_wdata[9:0];
            REG_GRID_HGT:   gh_ff   <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // item fields
   logic [1:0]  act_ff;
   logic [16:0] lx_ff, ly_ff;
   logic [15:0] ang_ff, mul_a_ff;
   logic        over_ff;
   logic signed [10:0] cx_ff, cy_ff;
   logic [31:0] prod_ff;
   logic [16:0] cnt_ff;
   logic signed [33:0] x_ff, y_ff;
   logic signed [20:0] z_ff;
   logic [3:0]  it_ff;
   logic signed [19:0] dx_ff, dy_ff;
   logic signed [35:0] px_ff, py_ff;
   logic [ADDR_W-1:0] addr_ff, clr_ff;
   logic        ok_ff;
   logic [7:0]  rd_ff;
   logic [7:0]  res_val_ff, rsp_val_ff;
   logic        res_in_ff, rsp_in_ff;

   logic [15:0] range_w;
   logic signed [33:0] xs, ys, c_w, s_w;
   logic [19:0] colv, rowv;
   logic        okc, okr, ok_in;
   logic [12:0] w_eff, h_eff;
   logic [ADDR_W-1:0] addr_in;
   logic signed [9:0] curw, freew, hitw, newf, newh;
   logic [7:0]  res_w;
   logic        wr_en;

   assign range_w = req_tdata[65:50];
   assign xs = x_ff >>> it_ff;
   assign ys = y_ff >>> it_ff;

   always_comb begin
      case (ang_ff[15:14])
         2'd0:    begin c_w = x_ff;  s_w = y_ff;  end
         2'd1:    begin c_w = -y_ff; s_w = x_ff;  end
         2'd2:    begin c_w = -x_ff; s_w = -y_ff; end
         default: begin c_w = y_ff;  s_w = -x_ff; end
      endcase
   end

   assign w_eff = (13'(gw_ff) > SIDE13) ? SIDE13 : 13'(gw_ff);
   assign h_eff = (13'(gh_ff) > SIDE13) ? SIDE13 : 13'(gh_ff);

   // cell position: truncation toward zero of the ray position
   always_comb begin
      if (act_ff == ACT_RAY) begin
         colv = px_ff[35] ? 20'd0 : px_ff[35:16];
         okc  = !px_ff[35] || (px_ff > -36'sd65536);
         rowv = py_ff[35] ? 20'd0 : py_ff[35:16];
         okr  = !py_ff[35] || (py_ff > -36'sd65536);
      end else begin
         colv = 20'(cx_ff[9:0]);
         okc  = !cx_ff[10];
         rowv = 20'(cy_ff[9:0]);
         okr  = !cy_ff[10];
      end
      ok_in   = okc && okr && (colv < 20'(w_eff)) && (rowv < 20'(h_eff));
      addr_in = ADDR_W'(rowv[CW-1:0]) * ADDR_W'(GRID_SIDE) + ADDR_W'(colv[CW-1:0]);
   end

   // saturating score update
   always_comb begin
      curw  = {{2{rd_ff[7]}}, rd_ff};
      freew = signed'({3'b000, free_ff});
      hitw  = signed'({3'b000, hit_ff});
      if (curw > -10'sd128 + freew) newf = curw - freew;
      else                          newf = -10'sd128;
      if (curw < 10'sd0)                   newh = hitw;
      else if (curw < 10'sd127 - hitw)     newh = curw + hitw;
      else                                 newh = 10'sd127;
      case (act_ff)
         ACT_RAY: res_w = newf[7:0];
         ACT_HIT: res_w = newh[7:0];
         default: res_w = rd_ff;
      endcase
      wr_en = cmd.wr && ok_ff && (act_ff == ACT_RAY || act_ff == ACT_HIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.load) begin
         clr_ff <= '0;
      end else if (cmd.clr) begin
         clr_ff <= clr_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mem[clr_ff] <= 8'd0;
      end else if (wr_en) begin
         mem[addr_ff] <= res_w;
      end
      rd_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff     <= req_tuser;
         lx_ff      <= req_tdata[16:0];
         ly_ff      <= req_tdata[33:17];
         ang_ff     <= req_tdata[49:34];
         cx_ff      <= signed'(req_tdata[76:66]);
         cy_ff      <= signed'(req_tdata[87:77]);
         over_ff    <= range_w > maxr_ff;
         mul_a_ff   <= (range_w > maxr_ff) ? maxr_ff : range_w;
         res_val_ff <= 8'd0;
         res_in_ff  <= 1'b0;
      end
      if (cmd.mul) begin
         prod_ff <= 32'(mul_a_ff) * 32'(cpm_ff);
      end
      if (cmd.cinit) begin
         cnt_ff <= 17'(prod_ff[31:16]) + 17'(!over_ff);
         x_ff   <= CORDIC_START;
         y_ff   <= '0;
         z_ff   <= signed'(21'({ang_ff[13:0], 4'b0000}));
         it_ff  <= '0;
      end
      if (cmd.cstep) begin
         if (z_ff >= 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - arc_entry(it_ff);
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + arc_entry(it_ff);
         end
         it_ff <= it_ff + 4'd1;
      end
      if (cmd.quad) begin
         dx_ff <= c_w[33:14];
         dy_ff <= s_w[33:14];
         px_ff <= signed'({11'd0, lx_ff, 8'd0});
         py_ff <= signed'({11'd0, ly_ff, 8'd0});
      end
      if (cmd.addr) begin
         addr_ff <= addr_in;
         ok_ff   <= ok_in;
      end
      if (cmd.wr) begin
         res_val_ff <= ok_ff ? res_w : 8'd0;
         res_in_ff  <= ok_ff;
         px_ff      <= px_ff + {{16{dx_ff[19]}}, dx_ff};
         py_ff      <= py_ff + {{16{dy_ff[19]}}, dy_ff};
         cnt_ff     <= cnt_ff - 17'd1;
      end
      if (cmd.out_load) begin
         rsp_val_ff <= res_val_ff;
         rsp_in_ff  <= res_in_ff;
      end
   end

   assign status.action     = cmd.load ? req_tuser : act_ff;
   assign status.cord_last  = (it_ff == CORDIC_LAST);
   assign status.steps_zero = (cnt_ff == 17'd0);
   assign status.cnt_last   = (cnt_ff == 17'd1);
   assign status.clr_last   = (clr_ff == ADDR_W'(DEPTH - 1));

   assign rsp_tdata = rsp_val_ff;
   assign rsp_tuser = rsp_in_ff;

endmodule

// ----- hdl/occupancy_grid_ray_update_top.sv -----
// a ray takes the step multiplier, the cordic (16 iterations), then per step a
// read-modify-write over the single grid memory; hit does one read-modify-write,
// read one read; clear zeroes the grid, one memory entry per cycle
// one item is worked at a time; the next is taken while a result waits
// reset: synchronous, active high; a clearing pass zeroes the grid before
// the first item is taken
module occupancy_grid_ray_update_top #(
   parameter int GRID_SIDE = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration write port
   input  logic                            csr_wen,
   input  logic [2:0]                      csr_index,
   input  logic [ogru_pkg::CSR_DATA_W-1:0] csr_wdata,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // laser_x, laser_y, ray_angle, ray_range, cell_x, cell_y
   input  logic [ogru_pkg::REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [1:0]                      req_tuser,
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // cell_value
   output logic [ogru_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // in_grid
   output logic                            rsp_tuser
);
   import ogru_pkg::*;

   ogru_cmd_type    cmd;
   ogru_status_type status;

   // sequencer: accepts a transfer only in idle, holds finished result
   ogru_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: registers, step multiplier, cordic, ray walker and grid memory
   ogru_dpath #(
      .GRID_SIDE (GRID_SIDE)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
